>>> src/cgcm_pkg.sv
`timescale 1ns / 1ps
package cgcm_pkg;

    localparam int GLYPH_COUNT = 111;
    localparam logic [5:0] SEARCH_INIT_DIFF = 6'd8;
    localparam logic [31:0] SEARCH_INIT_PAT = 32'h0000ffff;
    localparam logic [15:0] SEARCH_INIT_CP = 16'h2584;
    localparam logic [6:0] DIRECT_MIN = 7'd16;
    localparam logic [4:0] LAST_PIXEL = 5'd31;
    localparam logic [2:0] LAST_AVG = 3'd5;
    localparam logic [7:0] CHAN_MAX = 8'd255;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CAND_RD,
        OP_CAND_CAP,
        OP_COUNT,
        OP_RANK,
        OP_MODE,
        OP_MINMAX,
        OP_MID,
        OP_MASK,
        OP_SEARCH,
        OP_SUM,
        OP_DIV_START,
        OP_DIV_WAIT,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic wr;
    } t_dp_cmd;

    typedef struct packed {
        logic pix_last;
        logic idx_last;
        logic outer_last;
        logic direct;
        logic div_done;
        logic ch_last;
    } t_dp_stat;

    typedef struct packed {
        logic [31:0] pat;
        logic [15:0] cp;
        logic        tt;
    } t_glyph;

    function automatic logic [7:0] chan_of(input logic [23:0] rgb, input logic [1:0] c);
        logic [7:0] v;
        case (c)
            2'd0: v = rgb[23:16];
            2'd1: v = rgb[15:8];
            default: v = rgb[7:0];
        endcase
        return v;
    endfunction

    function automatic t_glyph glyph_at(input logic [6:0] idx);
        t_glyph g;
        case (idx)
            7'd0:   g = '{32'h00000000, 16'h00a0, 1'b0};
            7'd1:   g = '{32'h0000000f, 16'h2581, 1'b0};
            7'd2:   g = '{32'h000000ff, 16'h2582, 1'b0};
            7'd3:   g = '{32'h00000fff, 16'h2583, 1'b0};
            7'd4:   g = '{32'h0000ffff, 16'h2584, 1'b0};
            7'd5:   g = '{32'h000fffff, 16'h2585, 1'b0};
            7'd6:   g = '{32'h00ffffff, 16'h2586, 1'b0};
            7'd7:   g = '{32'h0fffffff, 16'h2587, 1'b0};
            7'd8:   g = '{32'heeeeeeee, 16'h258a, 1'b0};
            7'd9:   g = '{32'hcccccccc, 16'h258c, 1'b0};
            7'd10:  g = '{32'h88888888, 16'h258e, 1'b0};
            7'd11:  g = '{32'h0000cccc, 16'h2596, 1'b0};
            7'd12:  g = '{32'h00003333, 16'h2597, 1'b0};
            7'd13:  g = '{32'hcccc0000, 16'h2598, 1'b0};
            7'd14:  g = '{32'hcccc3333, 16'h259a, 1'b0};
            7'd15:  g = '{32'h33330000, 16'h259d, 1'b0};
            7'd16:  g = '{32'h000ff000, 16'h2501, 1'b0};
            7'd17:  g = '{32'h66666666, 16'h2503, 1'b0};
            7'd18:  g = '{32'h00077666, 16'h250f, 1'b0};
            7'd19:  g = '{32'h000ee666, 16'h2513, 1'b0};
            7'd20:  g = '{32'h66677000, 16'h2517, 1'b0};
            7'd21:  g = '{32'h666ee000, 16'h251b, 1'b0};
            7'd22:  g = '{32'h66677666, 16'h2523, 1'b0};
            7'd23:  g = '{32'h666ee666, 16'h252b, 1'b0};
            7'd24:  g = '{32'h000ff666, 16'h2533, 1'b0};
            7'd25:  g = '{32'h666ff000, 16'h253b, 1'b0};
            7'd26:  g = '{32'h666ff666, 16'h254b, 1'b0};
            7'd27:  g = '{32'h000cc000, 16'h2578, 1'b0};
            7'd28:  g = '{32'h00066000, 16'h2579, 1'b0};
            7'd29:  g = '{32'h00033000, 16'h257a, 1'b0};
            7'd30:  g = '{32'h00066000, 16'h257b, 1'b0};
            7'd31:  g = '{32'h06600660, 16'h254f, 1'b0};
            7'd32:  g = '{32'h000f0000, 16'h2500, 1'b0};
            7'd33:  g = '{32'h0000f000, 16'h2500, 1'b0};
            7'd34:  g = '{32'h44444444, 16'h2502, 1'b0};
            7'd35:  g = '{32'h22222222, 16'h2502, 1'b0};
            7'd36:  g = '{32'h000e0000, 16'h2574, 1'b0};
            7'd37:  g = '{32'h0000e000, 16'h2574, 1'b0};
            7'd38:  g = '{32'h44440000, 16'h2575, 1'b0};
            7'd39:  g = '{32'h22220000, 16'h2575, 1'b0};
            7'd40:  g = '{32'h00030000, 16'h2576, 1'b0};
            7'd41:  g = '{32'h00003000, 16'h2576, 1'b0};
            7'd42:  g = '{32'h00004444, 16'h2577, 1'b0};
            7'd43:  g = '{32'h00002222, 16'h2577, 1'b0};
            7'd44:  g = '{32'h44444444, 16'h23a2, 1'b0};
            7'd45:  g = '{32'h22222222, 16'h23a5, 1'b0};
            7'd46:  g = '{32'h0f000000, 16'h23ba, 1'b0};
            7'd47:  g = '{32'h00f00000, 16'h23bb, 1'b0};
            7'd48:  g = '{32'h00000f00, 16'h23bc, 1'b0};
            7'd49:  g = '{32'h000000f0, 16'h23bd, 1'b0};
            7'd50:  g = '{32'h00066000, 16'h25aa, 1'b0};
            7'd51:  g = '{32'hccc00000, 16'hfb00, 1'b1};
            7'd52:  g = '{32'h33300000, 16'hfb01, 1'b1};
            7'd53:  g = '{32'hfff00000, 16'hfb02, 1'b1};
            7'd54:  g = '{32'h000cc000, 16'hfb03, 1'b1};
            7'd55:  g = '{32'hccccc000, 16'hfb04, 1'b1};
            7'd56:  g = '{32'h333cc000, 16'hfb05, 1'b1};
            7'd57:  g = '{32'hfffcc000, 16'hfb06, 1'b1};
            7'd58:  g = '{32'h00033000, 16'hfb07, 1'b1};
            7'd59:  g = '{32'hccc33000, 16'hfb08, 1'b1};
            7'd60:  g = '{32'h33333000, 16'hfb09, 1'b1};
            7'd61:  g = '{32'hfff33000, 16'hfb0a, 1'b1};
            7'd62:  g = '{32'h000ff000, 16'hfb0b, 1'b1};
            7'd63:  g = '{32'hcccff000, 16'hfb0c, 1'b1};
            7'd64:  g = '{32'h333ff000, 16'hfb0d, 1'b1};
            7'd65:  g = '{32'hfffff000, 16'hfb0e, 1'b1};
            7'd66:  g = '{32'h00000ccc, 16'hfb0f, 1'b1};
            7'd67:  g = '{32'hccc00ccc, 16'hfb10, 1'b1};
            7'd68:  g = '{32'h33300ccc, 16'hfb11, 1'b1};
            7'd69:  g = '{32'hfff00ccc, 16'hfb12, 1'b1};
            7'd70:  g = '{32'h000ccccc, 16'hfb13, 1'b1};
            7'd71:  g = '{32'h333ccccc, 16'hfb14, 1'b1};
            7'd72:  g = '{32'hfffccccc, 16'hfb15, 1'b1};
            7'd73:  g = '{32'h00033ccc, 16'hfb16, 1'b1};
            7'd74:  g = '{32'hccc33ccc, 16'hfb17, 1'b1};
            7'd75:  g = '{32'h33333ccc, 16'hfb18, 1'b1};
            7'd76:  g = '{32'hfff33ccc, 16'hfb19, 1'b1};
            7'd77:  g = '{32'h000ffccc, 16'hfb1a, 1'b1};
            7'd78:  g = '{32'hcccffccc, 16'hfb1b, 1'b1};
            7'd79:  g = '{32'h333ffccc, 16'hfb1c, 1'b1};
            7'd80:  g = '{32'hfffffccc, 16'hfb1d, 1'b1};
            7'd81:  g = '{32'h00000333, 16'hfb1e, 1'b1};
            7'd82:  g = '{32'hccc00333, 16'hfb1f, 1'b1};
            7'd83:  g = '{32'h33300333, 16'h1b20, 1'b1};
            7'd84:  g = '{32'hfff00333, 16'h1b21, 1'b1};
            7'd85:  g = '{32'h000cc333, 16'h1b22, 1'b1};
            7'd86:  g = '{32'hccccc333, 16'h1b23, 1'b1};
            7'd87:  g = '{32'h333cc333, 16'h1b24, 1'b1};
            7'd88:  g = '{32'hfffcc333, 16'h1b25, 1'b1};
            7'd89:  g = '{32'h00033333, 16'h1b26, 1'b1};
            7'd90:  g = '{32'hccc33333, 16'h1b27, 1'b1};
            7'd91:  g = '{32'hfff33333, 16'h1b28, 1'b1};
            7'd92:  g = '{32'h000ff333, 16'h1b29, 1'b1};
            7'd93:  g = '{32'hcccff333, 16'h1b2a, 1'b1};
            7'd94:  g = '{32'h333ff333, 16'h1b2b, 1'b1};
            7'd95:  g = '{32'hfffff333, 16'h1b2c, 1'b1};
            7'd96:  g = '{32'h00000fff, 16'h1b2d, 1'b1};
            7'd97:  g = '{32'hccc00fff, 16'h1b2e, 1'b1};
            7'd98:  g = '{32'h33300fff, 16'h1b2f, 1'b1};
            7'd99:  g = '{32'hfff00fff, 16'h1b30, 1'b1};
            7'd100: g = '{32'h000ccfff, 16'h1b31, 1'b1};
            7'd101: g = '{32'hcccccfff, 16'h1b32, 1'b1};
            7'd102: g = '{32'h333ccfff, 16'h1b33, 1'b1};
            7'd103: g = '{32'hfffccfff, 16'h1b34, 1'b1};
            7'd104: g = '{32'h00033fff, 16'h1b35, 1'b1};
            7'd105: g = '{32'hccc33fff, 16'h1b36, 1'b1};
            7'd106: g = '{32'h33333fff, 16'h1b37, 1'b1};
            7'd107: g = '{32'hfff33fff, 16'h1b38, 1'b1};
            7'd108: g = '{32'h000fffff, 16'h1b39, 1'b1};
            7'd109: g = '{32'hcccfffff, 16'h1b3a, 1'b1};
            7'd110: g = '{32'h333fffff, 16'h1b3b, 1'b1};
            default: g = '{32'h00000000, 16'h0000, 1'b1};
        endcase
        return g;
    endfunction

endpackage

>>> src/cgcm_ram.sv
`timescale 1ns / 1ps
module cgcm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/cgcm_divider.sv
`timescale 1ns / 1ps
module cgcm_divider import cgcm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [12:0] i_dividend,
    input  logic [5:0]  i_divisor,
    output logic        o_done,
    output logic [12:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_step;
    logic [12:0] r_q;
    logic [5:0]  r_rem;
    logic [5:0]  r_div;
    logic [6:0]  w_trial;
    logic        w_ge;
    logic [6:0]  w_diff;

    // restoring division, one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_q[12]};
        w_ge    = w_trial >= {1'b0, r_div};
        w_diff  = w_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 4'd0;
            end else if (r_busy) begin
                r_step <= r_step + 4'd1;
                if (r_step == 4'd12) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= 6'd0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[11:0], w_ge};
            r_rem <= w_ge ? w_diff[5:0] : w_trial[5:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

>>> src/cgcm_datapath.sv
`timescale 1ns / 1ps
module cgcm_datapath import cgcm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic [23:0] i_pixel,
    input  logic        i_teletext_enable,
    output logic [63:0] o_result
);

    logic [6:0]  r_idx;
    logic [4:0]  r_pix;
    logic [4:0]  r_outer;
    logic [2:0]  r_ch;
    logic        r_rd_vld;
    t_op         r_rd_op;
    logic [4:0]  r_rd_addr;
    logic        r_m_vld;

    logic [23:0] r_cand;
    logic [5:0]  r_cnt;
    logic [23:0] r_c1, r_c2;
    logic [5:0]  r_n1, r_n2;
    logic        r_v1, r_v2;
    logic        r_direct;

    logic [2:0][7:0]  r_lo, r_hi;
    logic [1:0]       r_sel;
    logic [7:0]       r_mid;
    logic [2:0][15:0] r_sq1, r_sq2;
    logic             r_gt;
    logic [31:0]      r_bits;

    logic [5:0]  r_best;
    logic [31:0] r_best_pat;
    logic [15:0] r_cp;
    logic        r_inv;

    logic [2:0][12:0] r_fsum, r_bsum;
    logic [5:0]       r_nf;
    logic [7:0]       r_avg [6];

    logic [15:0]     r_out_cp;
    logic [2:0][7:0] r_out_fg, r_out_bg;

    logic        w_sweep;
    logic [4:0]  w_rd_addr;
    logic [23:0] w_rd_data;
    logic [29:0] w_key_c, w_key1, w_key2;
    logic        w_same;
    logic [6:0]  w_ntot;
    logic [2:0][7:0] w_range;
    logic [1:0]  w_sel;
    logic [7:0]  w_rng;
    logic [17:0] w_d1, w_d2;
    t_glyph      w_g;
    logic        w_skip;
    logic [5:0]  w_d, w_dc;
    logic [5:0]  w_best;
    logic [31:0] w_pat;
    logic [15:0] w_cp;
    logic        w_inv;
    logic        w_set;
    logic [5:0]  w_nb;
    logic [12:0] w_dividend;
    logic [5:0]  w_divisor;
    logic        w_div_done;
    logic [12:0] w_quot;
    logic [23:0] w_fcol, w_bcol;

    assign w_sweep = (i_cmd.op == OP_COUNT) || (i_cmd.op == OP_MINMAX) ||
                     (i_cmd.op == OP_MASK) || (i_cmd.op == OP_SUM);
    assign w_rd_addr = (i_cmd.op == OP_CAND_RD) ? r_outer : r_idx[4:0];

    cgcm_ram #(
        .WIDTH(24),
        .DEPTH(32)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.wr),
        .i_wr_addr(r_pix),
        .i_wr_data(i_pixel),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    assign w_nb       = 6'd32 - r_nf;
    assign w_dividend = (r_ch < 3'd3) ? r_fsum[r_ch[1:0]] : r_bsum[2'(r_ch - 3'd3)];
    assign w_divisor  = (r_ch < 3'd3) ? r_nf : w_nb;

    cgcm_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.op == OP_DIV_START),
        .i_dividend(w_dividend),
        .i_divisor (w_divisor),
        .o_done    (w_div_done),
        .o_quotient(w_quot)
    );

    always_comb begin
        w_key_c = {r_cnt, r_cand};
        w_key1  = {r_n1, r_c1};
        w_key2  = {r_n2, r_c2};
        w_same  = (r_v1 && (r_cand == r_c1)) || (r_v2 && (r_cand == r_c2));
        w_ntot  = r_v2 ? ({1'b0, r_n1} + {1'b0, r_n2}) : {1'b0, r_n1};
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_range[c] = r_hi[c] - r_lo[c];
        end
        w_sel = 2'd0;
        w_rng = w_range[0];
        if (w_range[1] > w_rng) begin
            w_sel = 2'd1;
            w_rng = w_range[1];
        end
        if (w_range[2] > w_rng) begin
            w_sel = 2'd2;
            w_rng = w_range[2];
        end
    end

    assign w_d1 = 18'(r_sq1[0]) + 18'(r_sq1[1]) + 18'(r_sq1[2]);
    assign w_d2 = 18'(r_sq2[0]) + 18'(r_sq2[1]) + 18'(r_sq2[2]);

    always_comb begin
        w_g    = glyph_at(r_idx);
        w_skip = w_g.tt & ~i_teletext_enable;
        w_d    = 6'($countones(w_g.pat ^ r_bits));
        w_dc   = 6'd32 - w_d;
        w_best = r_best;
        w_pat  = r_best_pat;
        w_cp   = r_cp;
        w_inv  = r_inv;
        if (!w_skip && (w_d < w_best)) begin
            w_best = w_d;
            w_pat  = w_g.pat;
            w_cp   = w_g.cp;
            w_inv  = 1'b0;
        end
        if (!w_skip && (w_dc < w_best)) begin
            w_best = w_dc;
            w_pat  = w_g.pat;
            w_cp   = w_g.cp;
            w_inv  = 1'b1;
        end
    end

    assign w_set  = r_best_pat[~r_rd_addr];
    assign w_fcol = r_inv ? r_c1 : r_c2;
    assign w_bcol = r_inv ? r_c2 : r_c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= 7'd0;
            r_pix    <= 5'd0;
            r_outer  <= 5'd0;
            r_ch     <= 3'd0;
            r_rd_vld <= 1'b0;
            r_rd_op  <= OP_NONE;
            r_m_vld  <= 1'b0;
        end else begin
            r_idx    <= ((w_sweep || (i_cmd.op == OP_SEARCH)) && !o_stat.idx_last) ?
                        r_idx + 7'd1 : 7'd0;
            r_rd_vld <= w_sweep;
            r_rd_op  <= i_cmd.op;
            r_m_vld  <= r_rd_vld && (r_rd_op == OP_MASK);
            if (i_cmd.wr) begin
                r_pix <= r_pix + 5'd1;
                if (r_pix == LAST_PIXEL) begin
                    r_outer <= 5'd0;
                end
            end
            if (i_cmd.op == OP_RANK) begin
                r_outer <= r_outer + 5'd1;
            end
            if (i_cmd.op == OP_MODE) begin
                r_ch <= 3'd0;
            end
            if ((i_cmd.op == OP_DIV_WAIT) && w_div_done) begin
                r_ch <= r_ch + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_idx[4:0];
        if (i_cmd.wr && (r_pix == LAST_PIXEL)) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end
        if (i_cmd.op == OP_CAND_CAP) begin
            r_cand <= w_rd_data;
            r_cnt  <= 6'd0;
        end
        if (r_rd_vld && (r_rd_op == OP_COUNT) && (w_rd_data == r_cand)) begin
            r_cnt <= r_cnt + 6'd1;
        end
        if ((i_cmd.op == OP_RANK) && !w_same) begin
            if (!r_v1 || (w_key_c > w_key1)) begin
                r_c2 <= r_c1;
                r_n2 <= r_n1;
                r_v2 <= r_v1;
                r_c1 <= r_cand;
                r_n1 <= r_cnt;
                r_v1 <= 1'b1;
            end else if (!r_v2 || (w_key_c > w_key2)) begin
                r_c2 <= r_cand;
                r_n2 <= r_cnt;
                r_v2 <= 1'b1;
            end
        end
        if (i_cmd.op == OP_MODE) begin
            r_direct   <= w_ntot > DIRECT_MIN;
            if (!r_v2) begin
                r_c2 <= r_c1;
            end
            r_lo       <= {3{CHAN_MAX}};
            r_hi       <= '0;
            r_fsum     <= '0;
            r_bsum     <= '0;
            r_nf       <= 6'd0;
            r_best     <= SEARCH_INIT_DIFF;
            r_best_pat <= SEARCH_INIT_PAT;
            r_cp       <= SEARCH_INIT_CP;
            r_inv      <= 1'b0;
        end
        if (r_rd_vld && (r_rd_op == OP_MINMAX)) begin
            for (int c = 0; c < 3; c++) begin
                if (chan_of(w_rd_data, 2'(c)) < r_lo[c]) begin
                    r_lo[c] <= chan_of(w_rd_data, 2'(c));
                end
                if (chan_of(w_rd_data, 2'(c)) > r_hi[c]) begin
                    r_hi[c] <= chan_of(w_rd_data, 2'(c));
                end
            end
        end
        if (i_cmd.op == OP_MID) begin
            r_sel <= w_sel;
            r_mid <= r_lo[w_sel] + {1'b0, w_rng[7:1]};
        end
        if (r_rd_vld && (r_rd_op == OP_MASK)) begin
            for (int c = 0; c < 3; c++) begin
                logic [7:0] p, a, b, e1, e2;
                p  = chan_of(w_rd_data, 2'(c));
                a  = chan_of(r_c1, 2'(c));
                b  = chan_of(r_c2, 2'(c));
                e1 = (a > p) ? a - p : p - a;
                e2 = (b > p) ? b - p : p - b;
                r_sq1[c] <= e1 * e1;
                r_sq2[c] <= e2 * e2;
            end
            r_gt <= chan_of(w_rd_data, r_sel) > r_mid;
        end
        if (r_m_vld) begin
            r_bits <= {r_bits[30:0], r_direct ? (w_d1 > w_d2) : r_gt};
        end
        if (i_cmd.op == OP_SEARCH) begin
            r_best     <= w_best;
            r_best_pat <= w_pat;
            r_cp       <= w_cp;
            r_inv      <= w_inv;
        end
        if (r_rd_vld && (r_rd_op == OP_SUM)) begin
            for (int c = 0; c < 3; c++) begin
                if (w_set) begin
                    r_fsum[c] <= r_fsum[c] + 13'(chan_of(w_rd_data, 2'(c)));
                end else begin
                    r_bsum[c] <= r_bsum[c] + 13'(chan_of(w_rd_data, 2'(c)));
                end
            end
            if (w_set) begin
                r_nf <= r_nf + 6'd1;
            end
        end
        if ((i_cmd.op == OP_DIV_WAIT) && w_div_done) begin
            r_avg[r_ch] <= (w_divisor == 6'd0) ? 8'd0 : w_quot[7:0];
        end
        if (i_cmd.op == OP_OUT) begin
            r_out_cp <= r_cp;
            for (int c = 0; c < 3; c++) begin
                r_out_fg[c] <= r_direct ? chan_of(w_fcol, 2'(c)) : r_avg[c];
                r_out_bg[c] <= r_direct ? chan_of(w_bcol, 2'(c)) : r_avg[c + 3];
            end
        end
    end

    always_comb begin
        o_stat.pix_last   = r_pix == LAST_PIXEL;
        o_stat.idx_last   = (i_cmd.op == OP_SEARCH) ? (r_idx == 7'(GLYPH_COUNT - 1))
                                                    : (r_idx == 7'd31);
        o_stat.outer_last = r_outer == LAST_PIXEL;
        o_stat.direct     = r_direct;
        o_stat.div_done   = w_div_done;
        o_stat.ch_last    = r_ch == LAST_AVG;
    end

    assign o_result = {r_out_bg[2], r_out_bg[1], r_out_bg[0],
                       r_out_fg[2], r_out_fg[1], r_out_fg[0], r_out_cp};

endmodule

>>> src/cgcm_controller.sv
`timescale 1ns / 1ps
module cgcm_controller import cgcm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    output logic     o_m_tvalid,
    input  logic     i_m_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [19:0] {
        S_LOAD    = 20'h00001,
        S_CAND    = 20'h00002,
        S_CAP     = 20'h00004,
        S_CNT     = 20'h00008,
        S_CNT_W   = 20'h00010,
        S_RANK    = 20'h00020,
        S_MODE    = 20'h00040,
        S_BRANCH  = 20'h00080,
        S_MINMAX  = 20'h00100,
        S_MM_W    = 20'h00200,
        S_MID     = 20'h00400,
        S_MASK    = 20'h00800,
        S_MK_W1   = 20'h01000,
        S_MK_W2   = 20'h02000,
        S_SEARCH  = 20'h04000,
        S_SUM     = 20'h08000,
        S_SUM_W   = 20'h10000,
        S_DIV_GO  = 20'h20000,
        S_DIV_RUN = 20'h40000,
        S_DONE    = 20'h80000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;
    logic   w_out_load;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_out_load = (r_state == S_DONE) && w_out_free;

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = OP_NONE;
        o_cmd.wr  = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_cmd.op = OP_LOAD;
                o_cmd.wr = i_s_tvalid;
                if (i_s_tvalid && i_stat.pix_last) begin
                    n_state = S_CAND;
                end
            end
            S_CAND: begin
                o_cmd.op = OP_CAND_RD;
                n_state  = S_CAP;
            end
            S_CAP: begin
                o_cmd.op = OP_CAND_CAP;
                n_state  = S_CNT;
            end
            S_CNT: begin
                o_cmd.op = OP_COUNT;
                if (i_stat.idx_last) begin
                    n_state = S_CNT_W;
                end
            end
            S_CNT_W: n_state = S_RANK;
            S_RANK: begin
                o_cmd.op = OP_RANK;
                n_state  = i_stat.outer_last ? S_MODE : S_CAND;
            end
            S_MODE: begin
                o_cmd.op = OP_MODE;
                n_state  = S_BRANCH;
            end
            S_BRANCH: n_state = i_stat.direct ? S_MASK : S_MINMAX;
            S_MINMAX: begin
                o_cmd.op = OP_MINMAX;
                if (i_stat.idx_last) begin
                    n_state = S_MM_W;
                end
            end
            S_MM_W: n_state = S_MID;
            S_MID: begin
                o_cmd.op = OP_MID;
                n_state  = S_MASK;
            end
            S_MASK: begin
                o_cmd.op = OP_MASK;
                if (i_stat.idx_last) begin
                    n_state = S_MK_W1;
                end
            end
            S_MK_W1: n_state = S_MK_W2;
            S_MK_W2: n_state = S_SEARCH;
            S_SEARCH: begin
                o_cmd.op = OP_SEARCH;
                if (i_stat.idx_last) begin
                    n_state = i_stat.direct ? S_DONE : S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                if (i_stat.idx_last) begin
                    n_state = S_SUM_W;
                end
            end
            S_SUM_W: n_state = S_DIV_GO;
            S_DIV_GO: begin
                o_cmd.op = OP_DIV_START;
                n_state  = S_DIV_RUN;
            end
            S_DIV_RUN: begin
                o_cmd.op = OP_DIV_WAIT;
                if (i_stat.div_done) begin
                    n_state = i_stat.ch_last ? S_DONE : S_DIV_GO;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = r_state == S_LOAD;
    assign o_m_tvalid = r_out_valid;

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT) |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten while stalled");

    a_load_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT) |=> (o_m_tvalid && o_s_tready))
        else $error("result not presented after load");

    a_search_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && i_stat.idx_last) |=> (r_state == S_DONE || r_state == S_SUM))
        else $error("bad exit from glyph search");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_RUN && i_stat.div_done && i_stat.ch_last) |=> (r_state == S_DONE))
        else $error("averaging did not finish");

endmodule

>>> src/cell_glyph_color_matcher.sv
`timescale 1ns / 1ps
// Pixels: one transfer per cycle while loading, 32 per cell.
// After the last pixel, most of the work is the pairwise color count (32 passes
// over the single-read pixel RAM), in the two-color and the split case alike; the
// next cell is taken only once the result has moved to the output register.
// Reset (i_rst_n low, synchronous) clears the sequencer, counters, output valid
// and teletext_enable; the pixel RAM is not cleared.
module cell_glyph_color_matcher import cgcm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,   // teletext_enable
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,     // red, green, blue
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata      // code_point, fg rgb, bg rgb
);

    logic     r_teletext_enable;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_teletext_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_teletext_enable <= i_cfg_wdata;
        end
    end

    cgcm_controller u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    cgcm_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_pixel          ({i_s_tdata[7:0], i_s_tdata[15:8], i_s_tdata[23:16]}),
        .i_teletext_enable(r_teletext_enable),
        .o_result         (o_m_tdata)
    );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import cgcm_pkg::*;

    localparam int HOLD_CYCLES = 3000;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int SETTLE_CYCLES = 1600;

    localparam logic [31:0] GLYPH_PAT [GLYPH_COUNT] = '{
        32'h00000000, 32'h0000000f, 32'h000000ff, 32'h00000fff, 32'h0000ffff,
        32'h000fffff, 32'h00ffffff, 32'h0fffffff, 32'heeeeeeee, 32'hcccccccc,
        32'h88888888, 32'h0000cccc, 32'h00003333, 32'hcccc0000, 32'hcccc3333,
        32'h33330000, 32'h000ff000, 32'h66666666, 32'h00077666, 32'h000ee666,
        32'h66677000, 32'h666ee000, 32'h66677666, 32'h666ee666, 32'h000ff666,
        32'h666ff000, 32'h666ff666, 32'h000cc000, 32'h00066000, 32'h00033000,
        32'h00066000, 32'h06600660, 32'h000f0000, 32'h0000f000, 32'h44444444,
        32'h22222222, 32'h000e0000, 32'h0000e000, 32'h44440000, 32'h22220000,
        32'h00030000, 32'h00003000, 32'h00004444, 32'h00002222, 32'h44444444,
        32'h22222222, 32'h0f000000, 32'h00f00000, 32'h00000f00, 32'h000000f0,
        32'h00066000, 32'hccc00000, 32'h33300000, 32'hfff00000, 32'h000cc000,
        32'hccccc000, 32'h333cc000, 32'hfffcc000, 32'h00033000, 32'hccc33000,
        32'h33333000, 32'hfff33000, 32'h000ff000, 32'hcccff000, 32'h333ff000,
        32'hfffff000, 32'h00000ccc, 32'hccc00ccc, 32'h33300ccc, 32'hfff00ccc,
        32'h000ccccc, 32'h333ccccc, 32'hfffccccc, 32'h00033ccc, 32'hccc33ccc,
        32'h33333ccc, 32'hfff33ccc, 32'h000ffccc, 32'hcccffccc, 32'h333ffccc,
        32'hfffffccc, 32'h00000333, 32'hccc00333, 32'h33300333, 32'hfff00333,
        32'h000cc333, 32'hccccc333, 32'h333cc333, 32'hfffcc333, 32'h00033333,
        32'hccc33333, 32'hfff33333, 32'h000ff333, 32'hcccff333, 32'h333ff333,
        32'hfffff333, 32'h00000fff, 32'hccc00fff, 32'h33300fff, 32'hfff00fff,
        32'h000ccfff, 32'hcccccfff, 32'h333ccfff, 32'hfffccfff, 32'h00033fff,
        32'hccc33fff, 32'h33333fff, 32'hfff33fff, 32'h000fffff, 32'hcccfffff,
        32'h333fffff
    };
    localparam logic [15:0] GLYPH_CP [GLYPH_COUNT] = '{
        16'h00a0, 16'h2581, 16'h2582, 16'h2583, 16'h2584, 16'h2585, 16'h2586,
        16'h2587, 16'h258a, 16'h258c, 16'h258e, 16'h2596, 16'h2597, 16'h2598,
        16'h259a, 16'h259d, 16'h2501, 16'h2503, 16'h250f, 16'h2513, 16'h2517,
        16'h251b, 16'h2523, 16'h252b, 16'h2533, 16'h253b, 16'h254b, 16'h2578,
        16'h2579, 16'h257a, 16'h257b, 16'h254f, 16'h2500, 16'h2500, 16'h2502,
        16'h2502, 16'h2574, 16'h2574, 16'h2575, 16'h2575, 16'h2576, 16'h2576,
        16'h2577, 16'h2577, 16'h23a2, 16'h23a5, 16'h23ba, 16'h23bb, 16'h23bc,
        16'h23bd, 16'h25aa, 16'hfb00, 16'hfb01, 16'hfb02, 16'hfb03, 16'hfb04,
        16'hfb05, 16'hfb06, 16'hfb07, 16'hfb08, 16'hfb09, 16'hfb0a, 16'hfb0b,
        16'hfb0c, 16'hfb0d, 16'hfb0e, 16'hfb0f, 16'hfb10, 16'hfb11, 16'hfb12,
        16'hfb13, 16'hfb14, 16'hfb15, 16'hfb16, 16'hfb17, 16'hfb18, 16'hfb19,
        16'hfb1a, 16'hfb1b, 16'hfb1c, 16'hfb1d, 16'hfb1e, 16'hfb1f, 16'h1b20,
        16'h1b21, 16'h1b22, 16'h1b23, 16'h1b24, 16'h1b25, 16'h1b26, 16'h1b27,
        16'h1b28, 16'h1b29, 16'h1b2a, 16'h1b2b, 16'h1b2c, 16'h1b2d, 16'h1b2e,
        16'h1b2f, 16'h1b30, 16'h1b31, 16'h1b32, 16'h1b33, 16'h1b34, 16'h1b35,
        16'h1b36, 16'h1b37, 16'h1b38, 16'h1b39, 16'h1b3a, 16'h1b3b
    };
    localparam int FIRST_TELETEXT = 51;

    typedef struct packed {
        logic [7:0]  bg_blue;
        logic [7:0]  bg_green;
        logic [7:0]  bg_red;
        logic [7:0]  fg_blue;
        logic [7:0]  fg_green;
        logic [7:0]  fg_red;
        logic [15:0] code_point;
    } t_cell_color;

    class glyph_scoreboard;
        logic [23:0] cell_pix [32];
        logic [4:0]  pix_idx;
        logic        teletext_en;
        t_cell_color pending_cells [$];
        int          errors;

        function new();
            pix_idx = '0;
            teletext_en = 1'b0;
            errors = 0;
        endfunction

        function automatic int chan(logic [23:0] rgb, int c);
            return int'(rgb[23 - 8 * c -: 8]);
        endfunction

        function automatic int count_of(logic [23:0] color);
            int n;
            n = 0;
            for (int i = 0; i < 32; i++) begin
                if (cell_pix[i] == color) n++;
            end
            return n;
        endfunction

        function void note_pixel(logic [23:0] rgb);
            logic [31:0] k, k1, k2, mask, best_pat;
            logic [23:0] c1, c2, f, b;
            logic        have2, direct, inv, set;
            int          n2, d1, d2, win_dist, d, sel, range, mid, nf, nb;
            int          lo [3], hi [3], fs [3], bs [3];
            logic [15:0] cp;
            t_cell_color res;
            cell_pix[pix_idx] = rgb;
            if (pix_idx != LAST_PIXEL) begin
                pix_idx++;
                return;
            end
            pix_idx = '0;
            k1 = '0;
            c1 = cell_pix[0];
            for (int i = 0; i < 32; i++) begin
                k = (count_of(cell_pix[i]) << 24) | cell_pix[i];
                if (k > k1) begin
                    k1 = k;
                    c1 = cell_pix[i];
                end
            end
            c2 = c1;
            k2 = '0;
            have2 = 1'b0;
            for (int i = 0; i < 32; i++) begin
                if (cell_pix[i] != c1) begin
                    k = (count_of(cell_pix[i]) << 24) | cell_pix[i];
                    if (!have2 || k > k2) begin
                        k2 = k;
                        c2 = cell_pix[i];
                        have2 = 1'b1;
                    end
                end
            end
            n2 = count_of(c1) + (have2 ? count_of(c2) : 0);
            direct = n2 > 16;
            mask = '0;
            if (direct) begin
                for (int i = 0; i < 32; i++) begin
                    d1 = 0;
                    d2 = 0;
                    for (int c = 0; c < 3; c++) begin
                        d1 += (chan(c1, c) - chan(cell_pix[i], c)) ** 2;
                        d2 += (chan(c2, c) - chan(cell_pix[i], c)) ** 2;
                    end
                    mask = {mask[30:0], d1 > d2};
                end
            end else begin
                for (int c = 0; c < 3; c++) begin
                    lo[c] = 255;
                    hi[c] = 0;
                end
                for (int i = 0; i < 32; i++) begin
                    for (int c = 0; c < 3; c++) begin
                        if (chan(cell_pix[i], c) < lo[c]) lo[c] = chan(cell_pix[i], c);
                        if (chan(cell_pix[i], c) > hi[c]) hi[c] = chan(cell_pix[i], c);
                    end
                end
                sel = 0;
                range = 0;
                for (int c = 0; c < 3; c++) begin
                    if (hi[c] - lo[c] > range) begin
                        range = hi[c] - lo[c];
                        sel = c;
                    end
                end
                mid = lo[sel] + range / 2;
                for (int i = 0; i < 32; i++) begin
                    mask = {mask[30:0], chan(cell_pix[i], sel) > mid};
                end
            end
            win_dist = int'(SEARCH_INIT_DIFF);
            best_pat = SEARCH_INIT_PAT;
            cp = SEARCH_INIT_CP;
            inv = 1'b0;
            for (int g = 0; g < GLYPH_COUNT; g++) begin
                if (g < FIRST_TELETEXT || teletext_en) begin
                    d = $countones(GLYPH_PAT[g] ^ mask);
                    if (d < win_dist) begin
                        win_dist = d;
                        best_pat = GLYPH_PAT[g];
                        cp = GLYPH_CP[g];
                        inv = 1'b0;
                    end
                    d = $countones(~GLYPH_PAT[g] ^ mask);
                    if (d < win_dist) begin
                        win_dist = d;
                        best_pat = GLYPH_PAT[g];
                        cp = GLYPH_CP[g];
                        inv = 1'b1;
                    end
                end
            end
            if (direct) begin
                f = inv ? c1 : c2;
                b = inv ? c2 : c1;
            end else begin
                nf = 0;
                nb = 0;
                for (int c = 0; c < 3; c++) begin
                    fs[c] = 0;
                    bs[c] = 0;
                end
                for (int i = 0; i < 32; i++) begin
                    set = best_pat[31 - i];
                    for (int c = 0; c < 3; c++) begin
                        if (set) fs[c] += chan(cell_pix[i], c);
                        else bs[c] += chan(cell_pix[i], c);
                    end
                    if (set) nf++;
                    else nb++;
                end
                for (int c = 0; c < 3; c++) begin
                    fs[c] = nf != 0 ? fs[c] / nf : 0;
                    bs[c] = nb != 0 ? bs[c] / nb : 0;
                end
                f = {8'(fs[0]), 8'(fs[1]), 8'(fs[2])};
                b = {8'(bs[0]), 8'(bs[1]), 8'(bs[2])};
            end
            res.code_point = cp;
            {res.fg_red, res.fg_green, res.fg_blue} = f;
            {res.bg_red, res.bg_green, res.bg_blue} = b;
            pending_cells.push_back(res);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(logic [63:0] data);
            t_cell_color got, want;
            got = data;
            if (pending_cells.size() == 0) begin
                report("unexpected result", int'(got.code_point), 0);
                return;
            end
            want = pending_cells.pop_front();
            if (got.code_point != want.code_point)
                report("code_point", got.code_point, want.code_point);
            if (got.fg_red != want.fg_red) report("fg_red", got.fg_red, want.fg_red);
            if (got.fg_green != want.fg_green) report("fg_green", got.fg_green, want.fg_green);
            if (got.fg_blue != want.fg_blue) report("fg_blue", got.fg_blue, want.fg_blue);
            if (got.bg_red != want.bg_red) report("bg_red", got.bg_red, want.bg_red);
            if (got.bg_green != want.bg_green) report("bg_green", got.bg_green, want.bg_green);
            if (got.bg_blue != want.bg_blue) report("bg_blue", got.bg_blue, want.bg_blue);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;    // red, green, blue
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;    // code_point, fg rgb, bg rgb

    glyph_scoreboard sb;
    logic [23:0] cell_buf [32];
    logic        hold_sink;
    int          idle_cycles;

    cell_glyph_color_matcher uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 19) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // sink side: random stalls, plus one long hold-off on request
    initial begin
        int g;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                i_m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_sink = 1'b0;
            end
            g = gap_len();
            if (g > 0) begin
                i_m_tready = 1'b0;
                repeat (g - 1) @(negedge i_clk);
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task send_pixel(logic [23:0] rgb, bit no_gaps);
        int g;
        g = no_gaps ? 0 : gap_len();
        if (g > 0) begin
            i_s_tvalid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = {rgb[7:0], rgb[15:8], rgb[23:16]};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_pixel(rgb);
        @(negedge i_clk);
    endtask

    task send_cell(bit no_gaps);
        for (int i = 0; i < 32; i++) send_pixel(cell_buf[i], no_gaps);
        i_s_tvalid = 1'b0;
    endtask

    task drain_and_config(logic teletext);
        while (sb.pending_cells.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = teletext;
        sb.teletext_en = teletext;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [23:0] near_color(logic [23:0] base);
        logic [23:0] v;
        for (int c = 0; c < 3; c++) begin
            v[c * 8 +: 8] = base[c * 8 +: 8] ^ 8'($urandom_range(0, 3));
        end
        return v;
    endfunction

    task make_random_cell();
        logic [23:0] ca, cb;
        logic [23:0] pal [4];
        logic [31:0] pat;
        int mode, noise;
        mode = $urandom_range(0, 5);
        ca = 24'($urandom());
        cb = 24'($urandom());
        noise = $urandom_range(0, 12);
        for (int p = 0; p < 4; p++) begin
            pal[p] = 24'({6'($urandom()), 2'b0} * 24'h010101 ^ $urandom_range(0, 3));
        end
        pat = GLYPH_PAT[$urandom_range(0, GLYPH_COUNT - 1)] ^ (1 << $urandom_range(0, 31));
        for (int i = 0; i < 32; i++) begin
            case (mode)
                0: cell_buf[i] = $urandom_range(0, 31) < noise ? 24'($urandom()) :
                                 ($urandom_range(0, 1) ? ca : cb);
                1: cell_buf[i] = 24'($urandom());
                2: cell_buf[i] = pal[$urandom_range(0, 3)];
                3: cell_buf[i] = pat[31 - i] ? ca : cb;
                4: cell_buf[i] = pat[31 - i] ? near_color(ca) : near_color(cb);
                default: cell_buf[i] = $urandom_range(0, 15) == 0 ? cb : ca;
            endcase
        end
    endtask

    initial begin
        sb = new();
        hold_sink = 1'b0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // single color at both extremes
        foreach (cell_buf[i]) cell_buf[i] = 24'h000000;
        send_cell(1'b1);
        foreach (cell_buf[i]) cell_buf[i] = 24'hffffff;
        send_cell(1'b0);
        // two colors with equidistant pixels between them
        foreach (cell_buf[i]) cell_buf[i] = i < 4 ? 24'h010101 :
                                            (i[0] ? 24'h020202 : 24'h000000);
        send_cell(1'b0);
        drain_and_config(1'b1);
        // split on a tied range, teletext glyphs available
        foreach (cell_buf[i]) cell_buf[i] = {8'(i * 8), 8'(255 - i * 8), 8'(i)};
        send_cell(1'b0);
        foreach (cell_buf[i]) cell_buf[i] = i < 12 ? 24'hff0000 : {8'(i), 8'(i * 3), 8'hff};
        send_cell(1'b0);

        for (int phase = 0; phase < 4; phase++) begin
            drain_and_config(phase[0]);
            if (phase == 2) hold_sink = 1'b1;
            for (int n = 0; n < 7; n++) begin
                make_random_cell();
                send_cell(1'b0);
            end
        end
        drain_and_config(1'b0);
        for (int n = 0; n < 3; n++) begin
            make_random_cell();
            send_cell(1'b0);
        end

        while (sb.pending_cells.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
